// File: design/prq_pkg.sv
// prq_pkg: sizes, command and status codes, beat layouts and slot arithmetic
// for the priority ready queue. Depends on nothing.

package prq_pkg;

   localparam int DEPTH         = 16;
   localparam int TAG_BITS      = 8;
   localparam int PRIO_BITS     = 8;
   localparam int IDX_BITS      = $clog2(DEPTH);
   localparam int CNT_BITS      = $clog2(DEPTH + 1);
   localparam int FUNC_BITS     = 2;
   localparam int STATUS_BITS   = 2;

   localparam logic [FUNC_BITS-1:0] FN_APPEND = 2'd0;
   localparam logic [FUNC_BITS-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FN_ORDER  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   localparam int REQ_BITS  = FUNC_BITS + TAG_BITS + PRIO_BITS;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int REQ_PAD   = REQ_BYTES * 8 - REQ_BITS;
   localparam int RSP_BITS  = STATUS_BITS + CNT_BITS + 1 + TAG_BITS + PRIO_BITS;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic [REQ_PAD-1:0]   pad;
      logic [PRIO_BITS-1:0] proc_priority;
      logic [TAG_BITS-1:0]  proc_tag;
      logic [FUNC_BITS-1:0] func;
   } req_beat_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0]   head_priority;
      logic [TAG_BITS-1:0]    head_tag;
      logic                   head_valid;
      logic [CNT_BITS-1:0]    count;
      logic [STATUS_BITS-1:0] status;
   } rsp_beat_type;

   // circular slot: head + offset, offset never above DEPTH
   function automatic logic [IDX_BITS-1:0] slot_of(input logic [IDX_BITS-1:0] head,
                                                   input logic [CNT_BITS-1:0] offset);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(head) + (CNT_BITS + 1)'(offset);
      if (sum >= (CNT_BITS + 1)'(DEPTH)) begin
         sum = sum - (CNT_BITS + 1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

// File: design/priority_ready_queue_unit.sv
// priority_ready_queue_unit: bounded ready queue with append, remove head and
// stable priority sort over one entry table. Depends on prq_pkg.
//
//   channel | dir | beat fields (low bit up)
//   req     | in  | func[1:0], proc_tag[9:2], proc_priority[17:10], zero pad
//   rsp     | out | status[1:0], count[6:2], head_valid[7], head_tag, head_priority
//
// Append and remove: table update, head read, result load. Order: one
// compare/swap unit walks the table in passes of len entries, len from n down
// to 2, then head read and result load.
// The table has one write and one registered read port; one beat in work at a time.
// Reset clears count, head slot, rsp valid and the sequencer, not the table contents.
// A stalled result holds in the output register; the next request is taken meanwhile.

module priority_ready_queue_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // func, proc_tag, proc_priority, zero pad
   input  logic [prq_pkg::REQ_BYTES*8-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status, count, head_valid, head_tag, head_priority
   output logic [prq_pkg::RSP_BYTES*8-1:0]       rsp_tdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD0   = 3'd1;
   localparam logic [2:0] S_LD0   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_WLAST = 3'd4;
   localparam logic [2:0] S_HEAD  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam logic [prq_pkg::CNT_BITS-1:0] CNT_ONE   = prq_pkg::CNT_BITS'(1);
   localparam logic [prq_pkg::CNT_BITS-1:0] CNT_TWO   = prq_pkg::CNT_BITS'(2);
   localparam logic [prq_pkg::CNT_BITS-1:0] CNT_DEPTH = prq_pkg::CNT_BITS'(prq_pkg::DEPTH);

   prq_pkg::entry_type mem [prq_pkg::DEPTH];

   logic [2:0]                           state_ff, state_in;
   logic [prq_pkg::IDX_BITS-1:0]         head_ff, head_in;
   logic [prq_pkg::CNT_BITS-1:0]         count_ff, count_in;
   logic [prq_pkg::CNT_BITS-1:0]         len_ff, len_in;
   logic [prq_pkg::CNT_BITS-1:0]         k_ff, k_in;
   logic [prq_pkg::STATUS_BITS-1:0]      status_ff, status_in;
   prq_pkg::entry_type                   carry_ff, carry_in;
   prq_pkg::entry_type                   rd_data_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_beat_type                rsp_ff, rsp_in;

   prq_pkg::req_beat_type                req;
   logic                                 req_fire;
   logic                                 rsp_load;
   logic                                 wr_en;
   logic [prq_pkg::IDX_BITS-1:0]         wr_addr;
   prq_pkg::entry_type                   wr_data;
   logic [prq_pkg::IDX_BITS-1:0]         rd_addr;
   logic                                 swap;

   assign req        = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign swap       = carry_ff.prio > rd_data_ff.prio;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      status_in    = status_ff;
      carry_in     = carry_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = prq_pkg::slot_of(head_ff, count_ff);
      wr_data      = '{tag: req.proc_tag, prio: req.proc_priority};
      rd_addr      = prq_pkg::slot_of(head_ff, '0);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = prq_pkg::ST_OK;
               state_in  = S_HEAD;
               unique case (req.func)
                  prq_pkg::FN_APPEND: begin
                     if (count_ff == CNT_DEPTH) begin
                        status_in = prq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_ONE;
                     end
                  end
                  prq_pkg::FN_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = prq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_ONE;
                        head_in  = (count_ff == CNT_ONE) ? '0
                                                         : prq_pkg::slot_of(head_ff, CNT_ONE);
                     end
                  end
                  prq_pkg::FN_ORDER: begin
                     if (count_ff >= CNT_TWO) begin
                        len_in   = count_ff;
                        state_in = S_RD0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD0: begin
            state_in = S_LD0;
         end
         S_LD0: begin
            carry_in = rd_data_ff;
            rd_addr  = prq_pkg::slot_of(head_ff, CNT_ONE);
            k_in     = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            // stable: move the carried entry on only past a strictly lower priority
            wr_en   = 1'b1;
            wr_addr = prq_pkg::slot_of(head_ff, k_ff);
            rd_addr = prq_pkg::slot_of(head_ff, k_ff + CNT_TWO);
            if (swap) begin
               wr_data = rd_data_ff;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data_ff;
            end
            k_in = k_ff + CNT_ONE;
            if (k_ff + CNT_TWO == len_ff) begin
               state_in = S_WLAST;
            end
         end
         S_WLAST: begin
            wr_en   = 1'b1;
            wr_addr = prq_pkg::slot_of(head_ff, len_ff - CNT_ONE);
            wr_data = carry_ff;
            len_in  = len_ff - CNT_ONE;
            state_in = (len_ff - CNT_ONE >= CNT_TWO) ? S_RD0 : S_HEAD;
         end
         S_HEAD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_in.status     = status_ff;
               rsp_in.count      = count_ff;
               rsp_in.head_valid = (count_ff != '0);
               rsp_in.head_tag   = (count_ff != '0) ? rd_data_ff.tag  : '0;
               rsp_in.head_priority = (count_ff != '0) ? rd_data_ff.prio : '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      carry_ff  <= carry_in;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_DEPTH)
      else $error("queue count above depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == '0)
      else $error("empty queue with nonzero head slot");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("sequencer idle right after accept");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == prq_pkg::ST_FULL |-> rsp_ff.count == CNT_DEPTH)
      else $error("full status with room left");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.head_valid == (rsp_ff.count != '0))
      else $error("head_valid disagrees with count");

endmodule
